[rtl/core/tsr_pkg.sv]
// Shared types, codes and the CRC-32 byte step for the trace stream reader.
// No dependencies; imported by every module of the block.
package tsr_pkg;

    localparam int HEADER_BYTES      = 64;
    localparam int META_KEEP_CAP     = 256;
    localparam int HDR_IDX_W         = $clog2(HEADER_BYTES);
    localparam int HDR_CRC_END       = 52;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    // product pipeline steps, by header byte index being accepted
    localparam logic [HDR_IDX_W-1:0] MUL_LO_IDX = HDR_IDX_W'(32);
    localparam logic [HDR_IDX_W-1:0] MUL_HI_IDX = HDR_IDX_W'(33);
    localparam logic [HDR_IDX_W-1:0] MUL_SUM_IDX = HDR_IDX_W'(34);
    localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX = HDR_IDX_W'(HEADER_BYTES - 1);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_META,
        PH_PAYLOAD,
        PH_DONE,
        PH_HALT
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_META   = 2'd1,
        KIND_ELEM   = 2'd2,
        KIND_ERROR  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CORRUPT  = 2'd1,
        ST_DTYPE    = 2'd2,
        ST_NO_BLOCK = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CFG_MAGIC    = 3'd0,
        CFG_VERSION  = 3'd1,
        CFG_DTYPE    = 3'd2,
        CFG_MAX_EPB  = 3'd3,
        CFG_MAX_BC   = 3'd4,
        CFG_MAX_PAY  = 3'd5,
        CFG_MAX_META = 3'd6,
        CFG_UNUSED   = 3'd7
    } cfg_idx_t;

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_END  = 1'b1;

    typedef struct packed {
        logic [55:0] magic_word;
        logic [31:0] hdr_version;
        logic [31:0] half_float_code;
        logic [31:0] max_epb;
        logic [63:0] max_bc;
        logic [63:0] max_pay;
        logic [31:0] max_meta;
    } cfg_t;

    typedef struct packed {
        logic [55:0] magic;
        logic [7:0]  pad;
        logic [31:0] version;
        logic [31:0] dtype;
        logic [31:0] epb;
        logic [31:0] mdl;
        logic [63:0] bc;
        logic [63:0] pay;
        logic [31:0] hcrc;
        logic [63:0] rsvd;
        logic [31:0] crc;      // running CRC before final xor
        logic        prod_ovf; // 2*bc*epb does not fit 64 bits
        logic [63:0] prod2;
    } hdr_view_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

[rtl/core/trace_stream_reader_core.sv]
// Top level of the trace stream reader: byte parser, field checks, output register.
// Depends on tsr_pkg and tsr_hdr_check.
//
// Usage:
//   Input channel s_*: one word per cycle, s_operation selects a data byte or
//   end of stream. Result channel m_*: at most one word per input word, kind in
//   m_result_kind. Configuration goes through cfg_wr_en/cfg_addr/cfg_wr_data;
//   the user must write it only while the block is idle; the block does not check.
//   Throughput: one input word per cycle in all phases while s_ready is high. The
//   per-byte CRC step and field update sit between the state registers and
//   the result register; the header product bc*epb is formed in a shared
//   32x32 multiplier over header bytes 32..34, well before the check.
//   Results are registered on m_* in the cycle after the word that causes them.
//   Stall: s_ready drops only while a result is held and m_ready is low.
//   Reset (aresetn low, synchronous): header phase, config to defaults, the
//   result register emptied. After any error or a clean end, input is
//   consumed and ignored until reset.
module trace_stream_reader_core
    import tsr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_result_kind,
    output logic [1:0]  m_status,
    output logic [15:0] m_element_value,
    output logic [7:0]  m_metadata_value,
    output logic        m_last_in_block,
    output logic        m_last_in_trace,
    output logic [31:0] m_block_elements,
    output logic [63:0] m_total_blocks,
    output logic [63:0] m_created_time,
    output logic [31:0] m_metadata_bytes,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [63:0] cfg_wr_data
);

    cfg_t                 cfg_reg;
    phase_t               phase_reg, phase_next;
    logic [HDR_IDX_W-1:0] hidx_reg, hidx_next;
    logic [7:0]           hdr_reg [HEADER_BYTES];
    logic [31:0]          crc_reg, crc_next;
    logic [31:0]          meta_left_reg, meta_left_next;
    logic [63:0]          blocks_left_reg, blocks_left_next;
    logic [31:0]          elem_idx_reg, elem_idx_next;
    logic [7:0]           low_byte_reg;
    logic                 odd_reg, odd_next;
    logic [63:0]          p_lo_reg, p_hi_reg;
    logic                 ovf_reg;
    logic [63:0]          prod2_reg;

    logic [8*HEADER_BYTES-1:0] hflat;
    hdr_view_t            view;
    status_t              chk_status;
    logic [31:0]          crc_step;
    logic [31:0]          mul_a, mul_b;
    logic [63:0]          mul_p;
    logic [95:0]          prod96;
    logic [31:0]          meta_pos;
    logic [63:0]          bl_dec;
    logic                 lib;

    logic                 out_valid_reg;
    logic                 emit;
    kind_t                o_kind_next;
    status_t              o_status_next;
    logic [15:0]          o_elem_next;
    logic [7:0]           o_meta_next;
    logic                 o_lib_next, o_lit_next;
    logic [31:0]          o_epb_next, o_mdl_next;
    logic [63:0]          o_bc_next, o_time_next;
    logic [1:0]           o_kind_reg, o_status_reg;
    logic [15:0]          o_elem_reg;
    logic [7:0]           o_meta_reg;
    logic                 o_lib_reg, o_lit_reg;
    logic [31:0]          o_epb_reg, o_mdl_reg;
    logic [63:0]          o_bc_reg, o_time_reg;

    logic accept;
    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // header bytes packed, with the byte in flight standing in for the last one
    always_comb begin
        for (int k = 0; k < HEADER_BYTES; k++) begin
            hflat[8*k +: 8] = (k == HEADER_BYTES - 1) ? s_data_byte : hdr_reg[k];
        end
    end

    assign crc_step = crc_byte(crc_reg, s_data_byte);

    always_comb begin
        view.magic    = hflat[55:0];
        view.pad      = hflat[63:56];
        view.version  = hflat[95:64];
        view.dtype    = hflat[127:96];
        view.epb      = hflat[159:128];
        view.mdl      = hflat[191:160];
        view.bc       = hflat[255:192];
        view.pay      = hflat[319:256];
        view.hcrc     = hflat[447:416];
        view.rsvd     = hflat[511:448];
        view.crc      = crc_reg;
        view.prod_ovf = ovf_reg;
        view.prod2    = prod2_reg;
    end

    tsr_hdr_check u_check (
        .hdr    (view),
        .cfg    (cfg_reg),
        .status (chk_status)
    );

    // shared multiplier: low then high half of block count times epb
    assign mul_a  = (hidx_reg == MUL_LO_IDX) ? hflat[223:192] : hflat[255:224];
    assign mul_b  = hflat[159:128];
    assign mul_p  = mul_a * mul_b;
    assign prod96 = {p_hi_reg, 32'd0} + {32'd0, p_lo_reg};

    assign meta_pos = hflat[191:160] - meta_left_reg;
    assign bl_dec   = (blocks_left_reg != 64'd0) ? blocks_left_reg - 64'd1 : 64'd0;
    assign lib      = ({1'b0, elem_idx_reg} + 33'd1) >= {1'b0, hflat[159:128]};

    always_comb begin
        phase_next       = phase_reg;
        hidx_next        = hidx_reg;
        crc_next         = crc_reg;
        meta_left_next   = meta_left_reg;
        blocks_left_next = blocks_left_reg;
        elem_idx_next    = elem_idx_reg;
        odd_next         = odd_reg;
        emit             = 1'b0;
        o_kind_next      = KIND_ERROR;
        o_status_next    = ST_OK;
        o_elem_next      = '0;
        o_meta_next      = '0;
        o_lib_next       = 1'b0;
        o_lit_next       = 1'b0;
        o_epb_next       = '0;
        o_mdl_next       = '0;
        o_bc_next        = '0;
        o_time_next      = '0;
        if (accept && phase_reg != PH_HALT) begin
            if (s_operation == OP_END) begin
                phase_next = PH_HALT;
                if (phase_reg != PH_DONE) begin
                    emit          = 1'b1;
                    o_status_next = ST_CORRUPT;
                end
            end else begin
                unique case (phase_reg)
                    PH_DONE: begin
                        phase_next    = PH_HALT;
                        emit          = 1'b1;
                        o_status_next = ST_NO_BLOCK;
                    end
                    PH_HEADER: begin
                        if (32'(hidx_reg) < 32'(HDR_CRC_END)) begin
                            crc_next = crc_step;
                        end
                        hidx_next = hidx_reg + HDR_IDX_W'(1);
                        if (hidx_reg == HDR_LAST_IDX) begin
                            emit = 1'b1;
                            if (chk_status != ST_OK) begin
                                phase_next    = PH_HALT;
                                o_status_next = chk_status;
                            end else begin
                                meta_left_next   = hflat[191:160];
                                blocks_left_next = hflat[255:192];
                                crc_next         = CRC_INIT;
                                elem_idx_next    = '0;
                                odd_next         = 1'b0;
                                phase_next = (hflat[191:160] != 32'd0) ? PH_META : PH_PAYLOAD;
                                o_kind_next = KIND_HEADER;
                                o_epb_next  = hflat[159:128];
                                o_bc_next   = hflat[255:192];
                                o_time_next = hflat[383:320];
                                o_mdl_next  = hflat[191:160];
                            end
                        end
                    end
                    PH_META: begin
                        meta_left_next = meta_left_reg - 32'd1;
                        if (meta_left_reg == 32'd1) begin
                            phase_next = PH_PAYLOAD;
                        end
                        if ({1'b0, meta_pos} + 33'd1 < 33'(META_KEEP_CAP)) begin
                            emit        = 1'b1;
                            o_kind_next = KIND_META;
                            o_meta_next = s_data_byte;
                        end
                    end
                    PH_PAYLOAD: begin
                        crc_next = crc_step;
                        if (!odd_reg) begin
                            odd_next = 1'b1;
                        end else begin
                            odd_next    = 1'b0;
                            emit        = 1'b1;
                            o_kind_next = KIND_ELEM;
                            o_elem_next = {s_data_byte, low_byte_reg};
                            o_lib_next  = lib;
                            if (lib) begin
                                elem_idx_next    = '0;
                                blocks_left_next = bl_dec;
                                if (bl_dec == 64'd0) begin
                                    o_lit_next = 1'b1;
                                    if ((crc_step ^ CRC_INIT) != hflat[415:384]) begin
                                        phase_next    = PH_HALT;
                                        o_kind_next   = KIND_ERROR;
                                        o_status_next = ST_CORRUPT;
                                        o_elem_next   = '0;
                                        o_lib_next    = 1'b0;
                                        o_lit_next    = 1'b0;
                                    end else begin
                                        phase_next = PH_DONE;
                                    end
                                end
                            end else begin
                                elem_idx_next = elem_idx_reg + 32'd1;
                            end
                        end
                    end
                    default: begin
                        phase_next = PH_HALT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_HEADER;
            hidx_reg        <= '0;
            crc_reg         <= CRC_INIT;
            meta_left_reg   <= '0;
            blocks_left_reg <= '0;
            elem_idx_reg    <= '0;
            odd_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
            cfg_reg.magic_word      <= '0;
            cfg_reg.hdr_version     <= 32'd1;
            cfg_reg.half_float_code <= 32'd1;
            cfg_reg.max_epb         <= 32'd65536;
            cfg_reg.max_bc          <= 64'd1048576;
            cfg_reg.max_pay         <= 64'd1073741824;
            cfg_reg.max_meta        <= 32'd4096;
        end else begin
            phase_reg       <= phase_next;
            hidx_reg        <= hidx_next;
            crc_reg         <= crc_next;
            meta_left_reg   <= meta_left_next;
            blocks_left_reg <= blocks_left_next;
            elem_idx_reg    <= elem_idx_next;
            odd_reg         <= odd_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                unique case (cfg_idx_t'(cfg_addr))
                    CFG_MAGIC:    cfg_reg.magic_word      <= cfg_wr_data[55:0];
                    CFG_VERSION:  cfg_reg.hdr_version     <= cfg_wr_data[31:0];
                    CFG_DTYPE:    cfg_reg.half_float_code <= cfg_wr_data[31:0];
                    CFG_MAX_EPB:  cfg_reg.max_epb         <= cfg_wr_data[31:0];
                    CFG_MAX_BC:   cfg_reg.max_bc          <= cfg_wr_data;
                    CFG_MAX_PAY:  cfg_reg.max_pay         <= cfg_wr_data;
                    CFG_MAX_META: cfg_reg.max_meta        <= cfg_wr_data[31:0];
                    CFG_UNUSED:   ;
                endcase
            end
        end
    end

    // payload side: header bytes, product pipeline, low byte, result word
    always_ff @(posedge aclk) begin
        if (accept && s_operation == OP_DATA) begin
            if (phase_reg == PH_HEADER) begin
                hdr_reg[hidx_reg] <= s_data_byte;
                if (hidx_reg == MUL_LO_IDX) begin
                    p_lo_reg <= mul_p;
                end
                if (hidx_reg == MUL_HI_IDX) begin
                    p_hi_reg <= mul_p;
                end
                if (hidx_reg == MUL_SUM_IDX) begin
                    ovf_reg   <= prod96[95:63] != 33'd0;
                    prod2_reg <= {prod96[62:0], 1'b0};
                end
            end
            if (phase_reg == PH_PAYLOAD && !odd_reg) begin
                low_byte_reg <= s_data_byte;
            end
        end
        if (emit) begin
            o_kind_reg   <= o_kind_next;
            o_status_reg <= o_status_next;
            o_elem_reg   <= o_elem_next;
            o_meta_reg   <= o_meta_next;
            o_lib_reg    <= o_lib_next;
            o_lit_reg    <= o_lit_next;
            o_epb_reg    <= o_epb_next;
            o_bc_reg     <= o_bc_next;
            o_time_reg   <= o_time_next;
            o_mdl_reg    <= o_mdl_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_result_kind    = o_kind_reg;
    assign m_status         = o_status_reg;
    assign m_element_value  = o_elem_reg;
    assign m_metadata_value = o_meta_reg;
    assign m_last_in_block  = o_lib_reg;
    assign m_last_in_trace  = o_lit_reg;
    assign m_block_elements = o_epb_reg;
    assign m_total_blocks   = o_bc_reg;
    assign m_created_time   = o_time_reg;
    assign m_metadata_bytes = o_mdl_reg;

endmodule

[rtl/core/tsr_hdr_check.sv]
// Header validation: magic, CRC, reserved word, version, dtype and size limits.
// Depends on tsr_pkg; purely combinational, used on the final header byte.
module tsr_hdr_check
    import tsr_pkg::*;
(
    input  hdr_view_t hdr,
    input  cfg_t      cfg,
    output status_t   status
);

    always_comb begin
        priority if (hdr.magic != cfg.magic_word || hdr.pad != 8'd0) begin
            status = ST_CORRUPT;
        end else if ((hdr.crc ^ CRC_INIT) != hdr.hcrc) begin
            status = ST_CORRUPT;
        end else if (hdr.rsvd != 64'd0) begin
            status = ST_CORRUPT;
        end else if (hdr.mdl > cfg.max_meta) begin
            status = ST_CORRUPT;
        end else if (hdr.version != cfg.hdr_version) begin
            status = ST_CORRUPT;
        end else if (hdr.dtype != cfg.half_float_code) begin
            status = ST_DTYPE;
        end else if (hdr.epb == 32'd0 || hdr.epb > cfg.max_epb) begin
            status = ST_CORRUPT;
        end else if (hdr.bc == 64'd0 || hdr.bc > cfg.max_bc) begin
            status = ST_CORRUPT;
        end else if (hdr.prod_ovf) begin
            status = ST_CORRUPT;
        end else if (hdr.prod2 != hdr.pay || hdr.pay > cfg.max_pay) begin
            status = ST_CORRUPT;
        end else begin
            status = ST_OK;
        end
    end

endmodule

[dv/tb.sv]
// Testbench for trace_stream_reader_core: one trace file, header, metadata and payload words.
// Depends on tsr_pkg and the RTL; results are checked against a built-in predictor.
module tb;
    import tsr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_SHOWN   = 10;

    typedef struct packed {
        kind_t       kind;
        status_t     st;
        logic [15:0] elem;
        logic [7:0]  meta;
        logic        lib;
        logic        lit;
        logic [31:0] blk_elems;
        logic [63:0] tot_blocks;
        logic [63:0] ctime;
        logic [31:0] meta_len;
    } reader_out_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_operation = OP_DATA;
    logic [7:0]  s_data_byte = 8'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_result_kind;
    logic [1:0]  m_status;
    logic [15:0] m_element_value;
    logic [7:0]  m_metadata_value;
    logic        m_last_in_block;
    logic        m_last_in_trace;
    logic [31:0] m_block_elements;
    logic [63:0] m_total_blocks;
    logic [63:0] m_created_time;
    logic [31:0] m_metadata_bytes;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_addr = 3'd0;
    logic [63:0] cfg_wr_data = 64'd0;

    trace_stream_reader_core dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // register mirror
    logic [55:0] c_magic;
    logic [31:0] c_version, c_dtype, c_max_epb, c_max_meta;
    logic [63:0] c_max_bc, c_max_pay;

    // parser mirror
    phase_t      ph;
    int          byte_cnt;
    logic [63:0] hdr [8];
    logic [31:0] crc_run, pay_crc_exp, meta_left, elem_idx;
    logic [63:0] blocks_left;
    logic [7:0]  low_b;

    reader_out_t expected_q[$];
    logic [7:0]  trace_q[$];
    int          mismatches = 0;
    int          cycles = 0;
    int          send_idle = 0;
    int          recv_stall = 0;
    int          hold_cycles = 0;

    function automatic logic [31:0] crc32_step(logic [31:0] c, logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        repeat (8) r = r[0] ? ((r >> 1) ^ 32'hEDB8_8320) : (r >> 1);
        return r;
    endfunction

    function automatic status_t header_verdict();
        logic [31:0] epb, mdl;
        logic [127:0] prod;
        epb = hdr[2][31:0];
        mdl = hdr[2][63:32];
        if (hdr[0][55:0] != c_magic || hdr[0][63:56] != 8'd0) return ST_CORRUPT;
        if ((crc_run ^ 32'hFFFF_FFFF) != hdr[6][63:32]) return ST_CORRUPT;
        if (hdr[7] != 64'd0) return ST_CORRUPT;
        if (mdl > c_max_meta) return ST_CORRUPT;
        if (hdr[1][31:0] != c_version) return ST_CORRUPT;
        if (hdr[1][63:32] != c_dtype) return ST_DTYPE;
        if (epb == 0 || epb > c_max_epb) return ST_CORRUPT;
        if (hdr[3] == 0 || hdr[3] > c_max_bc) return ST_CORRUPT;
        prod = {64'd0, hdr[3]} * {96'd0, epb};
        prod = prod << 1;
        if (prod[127:64] != 0) return ST_CORRUPT;
        if (prod[63:0] != hdr[4] || prod[63:0] > c_max_pay) return ST_CORRUPT;
        return ST_OK;
    endfunction

    task automatic halt_with(status_t st);
        reader_out_t r;
        r = '0;
        r.kind = KIND_ERROR;
        r.st = st;
        ph = PH_HALT;
        expected_q.push_back(r);
    endtask

    task automatic predict_word(logic op, logic [7:0] b);
        reader_out_t r;
        status_t st;
        logic [31:0] idx, v;
        r = '0;
        if (ph == PH_HALT) return;
        if (op == OP_END) begin
            if (ph == PH_DONE) ph = PH_HALT;
            else halt_with(ST_CORRUPT);
            return;
        end
        if (ph == PH_DONE) begin
            halt_with(ST_NO_BLOCK);
            return;
        end
        case (ph)
            PH_HEADER: begin
                hdr[byte_cnt >> 3][(byte_cnt % 8) * 8 +: 8] = b;
                if (byte_cnt < 52) crc_run = crc32_step(crc_run, b);
                byte_cnt++;
                if (byte_cnt < 64) return;
                st = header_verdict();
                if (st != ST_OK) begin
                    halt_with(st);
                    return;
                end
                meta_left = hdr[2][63:32];
                blocks_left = hdr[3];
                pay_crc_exp = hdr[6][31:0];
                crc_run = 32'hFFFF_FFFF;
                elem_idx = 0;
                byte_cnt = 0;
                ph = (meta_left != 0) ? PH_META : PH_PAYLOAD;
                r.kind = KIND_HEADER;
                r.st = ST_OK;
                r.blk_elems = hdr[2][31:0];
                r.tot_blocks = hdr[3];
                r.ctime = hdr[5];
                r.meta_len = hdr[2][63:32];
                expected_q.push_back(r);
            end
            PH_META: begin
                idx = hdr[2][63:32] - meta_left;
                meta_left--;
                if (meta_left == 0) ph = PH_PAYLOAD;
                // bytes past the keep cap are swallowed
                if ({32'd0, idx} + 1 < META_KEEP_CAP) begin
                    r.kind = KIND_META;
                    r.meta = b;
                    expected_q.push_back(r);
                end
            end
            default: begin
                crc_run = crc32_step(crc_run, b);
                if (byte_cnt == 0) begin
                    low_b = b;
                    byte_cnt = 1;
                    return;
                end
                byte_cnt = 0;
                v = {16'd0, b, low_b};
                r.kind = KIND_ELEM;
                r.elem = v[15:0];
                if ({1'b0, elem_idx} + 33'd1 >= {1'b0, hdr[2][31:0]}) begin
                    r.lib = 1'b1;
                    elem_idx = 0;
                    if (blocks_left != 0) blocks_left--;
                    if (blocks_left == 0) begin
                        r.lit = 1'b1;
                        if ((crc_run ^ 32'hFFFF_FFFF) != pay_crc_exp) begin
                            halt_with(ST_CORRUPT);
                            return;
                        end
                        ph = PH_DONE;
                    end
                end else begin
                    elem_idx++;
                end
                expected_q.push_back(r);
            end
        endcase
    endtask

    task automatic send_word(logic op, logic [7:0] b);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_data_byte <= b;
        do @(posedge aclk); while (!s_ready);
        predict_word(op, b);
    endtask

    // the enable drops for one cycle between writes
    task automatic write_reg(cfg_idx_t idx, logic [63:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_MAGIC:    c_magic = val[55:0];
            CFG_VERSION:  c_version = val[31:0];
            CFG_DTYPE:    c_dtype = val[31:0];
            CFG_MAX_EPB:  c_max_epb = val[31:0];
            CFG_MAX_BC:   c_max_bc = val;
            CFG_MAX_PAY:  c_max_pay = val;
            CFG_MAX_META: c_max_meta = val[31:0];
            default: ;
        endcase
    endtask

    // block idle: results drained, sender parked, then a wait for words with no result
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic send_bytes(int n);
        repeat (n) begin
            if (trace_q.size() == 0) return;
            send_word(OP_DATA, trace_q.pop_front());
        end
    endtask

    // file contents: header with valid header CRC, metadata, payload (bad payload CRC in end_mode 2)
    int          n_meta, n_epb, n_bc, n_pay, end_mode;
    logic [63:0] ctime_v;

    task automatic build_trace();
        logic [7:0]  h [64];
        logic [7:0]  pay [$];
        logic [31:0] pc, hc;
        logic [63:0] w [8];
        pc = 32'hFFFF_FFFF;
        for (int i = 0; i < n_pay; i++) begin
            pay.push_back(8'($urandom));
            pc = crc32_step(pc, pay[i]);
        end
        pc ^= 32'hFFFF_FFFF;
        if (end_mode == 2) pc ^= 32'h1 << $urandom_range(31);
        w[0] = {8'd0, c_magic};
        w[1] = {c_dtype, c_version};
        w[2] = {32'(n_meta), 32'(n_epb)};
        w[3] = 64'(n_bc);
        w[4] = 64'(n_pay);
        w[5] = ctime_v;
        w[6] = {32'd0, pc};
        w[7] = 64'd0;
        for (int i = 0; i < 64; i++) h[i] = w[i / 8][(i % 8) * 8 +: 8];
        hc = 32'hFFFF_FFFF;
        for (int i = 0; i < 52; i++) hc = crc32_step(hc, h[i]);
        hc ^= 32'hFFFF_FFFF;
        for (int i = 0; i < 4; i++) h[52 + i] = hc[i * 8 +: 8];
        trace_q.delete();
        for (int i = 0; i < 64; i++) trace_q.push_back(h[i]);
        for (int i = 0; i < n_meta; i++) trace_q.push_back(8'($urandom));
        foreach (pay[i]) trace_q.push_back(pay[i]);
    endtask

    task automatic test_config();
        c_magic = 56'd0; c_version = 32'd1; c_dtype = 32'd1; c_max_epb = 32'd65536;
        c_max_bc = 64'd1048576; c_max_pay = 64'd1073741824; c_max_meta = 32'd4096;
        n_epb = $urandom_range(1, 8);
        n_bc = $urandom_range(20, 40);
        n_pay = 2 * n_epb * n_bc;
        n_meta = $urandom_range(280, 320);
        ctime_v = 64'hFFFF_FFFF_FFFF_FFFF;
        end_mode = $urandom_range(3);
        // limits sit exactly at the header values
        write_reg(CFG_MAGIC, {8'd0, 24'($urandom), $urandom});
        write_reg(CFG_VERSION, 64'($urandom));
        write_reg(CFG_DTYPE, 64'hFFFF_FFFF);
        write_reg(CFG_MAX_EPB, 64'(n_epb));
        write_reg(CFG_MAX_BC, 64'(n_bc));
        write_reg(CFG_MAX_PAY, 64'(n_pay));
        write_reg(CFG_MAX_META, 64'(n_meta));
        build_trace();
    endtask

    task automatic test_header();
        send_idle = 0; recv_stall = 0;
        send_bytes(64);
        wait_idle();
        // limits no longer matter once the header is in: sweep the extremes
        for (int i = 0; i < 7; i++) write_reg(cfg_idx_t'(i), 64'd0);
        for (int i = 0; i < 7; i++) write_reg(cfg_idx_t'(i), '1);
    endtask

    task automatic test_metadata();
        send_idle = 0; recv_stall = 0;
        send_bytes(20);
        hold_cycles = 200;
        send_bytes(40);
        send_idle = 69;
        send_bytes(80);
        send_idle = 0; recv_stall = 69;
        send_bytes(n_meta - 140);
        wait_idle();
        for (int i = 0; i < 7; i++) write_reg(cfg_idx_t'(i), {$urandom, $urandom});
    endtask

    task automatic test_payload();
        int q;
        q = n_pay / 4;
        send_idle = 0;  recv_stall = 0;  send_bytes(q);
        send_idle = 69; recv_stall = 0;  send_bytes(q);
        send_idle = 0;  recv_stall = 69; send_bytes(q);
        send_idle = 31; recv_stall = 31;
        if (end_mode == 3) begin
            send_bytes($urandom_range(1, trace_q.size() - 1));
            send_word(OP_END, 8'($urandom));
        end else begin
            send_bytes(trace_q.size());
        end
    endtask

    task automatic test_ending();
        if (end_mode == 1) send_word(OP_DATA, 8'($urandom));
        send_word(OP_END, 8'hFF);
        // halted: all of these are dropped
        repeat (5) send_word(1'($urandom), 8'($urandom));
        s_valid <= 1'b0;
    endtask

    always @(posedge aclk) begin
        reader_out_t got, exp_r;
        if (aresetn && m_valid && m_ready) begin
            got.kind = kind_t'(m_result_kind);
            got.st = status_t'(m_status);
            got.elem = m_element_value;
            got.meta = m_metadata_value;
            got.lib = m_last_in_block;
            got.lit = m_last_in_trace;
            got.blk_elems = m_block_elements;
            got.tot_blocks = m_total_blocks;
            got.ctime = m_created_time;
            got.meta_len = m_metadata_bytes;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected word: kind %0d status %0d", got.kind, got.st);
            end else begin
                exp_r = expected_q.pop_front();
                if (got !== exp_r) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN) begin
                        $display("mismatch exp k%0d s%0d e%h m%h b%b t%b %h %h %h %h",
                            exp_r.kind, exp_r.st, exp_r.elem, exp_r.meta, exp_r.lib,
                            exp_r.lit, exp_r.blk_elems, exp_r.tot_blocks, exp_r.ctime,
                            exp_r.meta_len);
                        $display("     got k%0d s%0d e%h m%h b%b t%b %h %h %h %h",
                            got.kind, got.st, got.elem, got.meta, got.lib, got.lit,
                            got.blk_elems, got.tot_blocks, got.ctime, got.meta_len);
                    end
                end
            end
        end
    end

    // receiver: long hold when requested, random stalls otherwise
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            m_ready <= 1'b0;
            hold_cycles--;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        ph = PH_HEADER;
        byte_cnt = 0;
        foreach (hdr[i]) hdr[i] = 64'd0;
        crc_run = 32'hFFFF_FFFF;
        pay_crc_exp = 0; meta_left = 0; blocks_left = 0; elem_idx = 0; low_b = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_config();
        test_header();
        test_metadata();
        test_payload();
        test_ending();
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
